// ----- sv/can_id_sequence_assembler_assert.svh -----
// Assertion macros for the CAN ID sequence assembler.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CAN_ID_SEQUENCE_ASSEMBLER_ASSERT_SVH
`define CAN_ID_SEQUENCE_ASSEMBLER_ASSERT_SVH

// Expression holds at every clock out of reset.
`define CISA_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define CISA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- sv/cisa_pkg.sv -----
// Types, constants and the ID table lookup of the CAN ID sequence assembler.
// No dependencies.
package cisa_pkg;

  localparam int ID_W     = 11;
  localparam int DATA_W   = 64;
  localparam int SLOT_W   = 4;
  localparam int TABLE_W  = 55;
  localparam int CFG_AW   = 2;

  localparam int TABLE_SLOTS = 10;
  localparam logic [SLOT_W-1:0] TABLE_SLOTS_C = SLOT_W'(TABLE_SLOTS);
  localparam logic [SLOT_W-1:0] OPT_RESET     = 4'd3;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_ID_LOW   = 2'd0,
    CFG_ID_HIGH  = 2'd1,
    CFG_ID_COUNT = 2'd2,
    CFG_OPT_SLOT = 2'd3
  } cfg_addr_t;

  // Expected ID of a slot; slots 0..4 in the low word, 5..9 in the high word.
  function automatic logic [ID_W-1:0] table_id(input logic [TABLE_W-1:0] lo,
                                               input logic [TABLE_W-1:0] hi,
                                               input logic [SLOT_W-1:0]  slot);
    logic [ID_W-1:0] id;
    case (slot)
      4'd0:    id = lo[10:0];
      4'd1:    id = lo[21:11];
      4'd2:    id = lo[32:22];
      4'd3:    id = lo[43:33];
      4'd4:    id = lo[54:44];
      4'd5:    id = hi[10:0];
      4'd6:    id = hi[21:11];
      4'd7:    id = hi[32:22];
      4'd8:    id = hi[43:33];
      4'd9:    id = hi[54:44];
      default: id = '0;
    endcase
    return id;
  endfunction

endpackage

// ----- sv/cisa_if.sv -----
// Valid/ready channel interfaces: frame/readout input and slot result output.
// Depends on cisa_pkg.
interface cisa_in_if;
  import cisa_pkg::*;

  logic                valid;
  logic                ready;
  op_t                 op;
  logic [ID_W-1:0]     frame_id;
  logic [DATA_W-1:0]   frame_data;

  modport source (output valid, output op, output frame_id, output frame_data,
                  input ready);
  modport sink   (input valid, input op, input frame_id, input frame_data,
                  output ready);
endinterface

interface cisa_out_if;
  import cisa_pkg::*;

  logic                valid;
  logic                ready;
  logic [SLOT_W-1:0]   slot_index;
  logic [DATA_W-1:0]   slot_data;
  logic                new_packet;
  logic                last;

  modport source (output valid, output slot_index, output slot_data,
                  output new_packet, output last, input ready);
  modport sink   (input valid, input slot_index, input slot_data,
                  input new_packet, input last, output ready);
endinterface

// ----- sv/cisa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cisa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 20
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/can_id_sequence_assembler.sv -----
// CAN ID sequence assembler: top level with sequencer, ID table and slot buffers.
// Depends on cisa_pkg, cisa_if, cisa_ram and can_id_sequence_assembler_assert.svh.
//
// Usage: words enter on in_ch (valid/ready). op = frame stores frame_data in
// the current slot of the write buffer when frame_id matches the expected ID;
// op = readout emits one out_ch word per slot of the last completed buffer,
// slot 0 first, with last set on the final one. A readout with a count of
// zero emits nothing. Registers are to be written on cfg_we only while the block
// is idle; the block itself does not enforce it. Timing: in_ch.ready is high
// only while the sequencer is idle. A frame walks the ID table one slot per
// cycle through a single shared comparator: one optional-skip compare, then up
// to count+1 search steps and one update step, then back to idle. A readout
// reads the buffer RAM one slot at a time in two steps (address, then load of
// the output register) and accepts no new in_ch word until its last slot is
// loaded. A stalled receiver holds the output register and the sequencer waits
// in its load step; no word is dropped. Reset (synchronous, rst_n low) clears
// the position, buffer selects, table and count, sets the optional slot to 3 and
// marks every buffer entry unwritten so it reads as zero; no clearing pass.
`include "can_id_sequence_assembler_assert.svh"

module can_id_sequence_assembler #(
  parameter int MAX_SLOTS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  cisa_pkg::cfg_addr_t           cfg_addr,
  input  logic [cisa_pkg::TABLE_W-1:0]  cfg_wdata,
  cisa_in_if.sink                       in_ch,
  cisa_out_if.source                    out_ch
);
  import cisa_pkg::*;

  localparam int DEPTH = 2 * MAX_SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CAP   = (MAX_SLOTS < TABLE_SLOTS) ? MAX_SLOTS : TABLE_SLOTS;
  localparam logic [SLOT_W-1:0] CAP_C   = SLOT_W'(CAP);
  localparam logic [AW-1:0]     BANK_B  = AW'(MAX_SLOTS);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SKIP   = 6'b000010,
    S_SEARCH = 6'b000100,
    S_APPLY  = 6'b001000,
    S_RADDR  = 6'b010000,
    S_RLOAD  = 6'b100000
  } state_t;

  state_t              state_r, state_nxt;
  logic [TABLE_W-1:0]  id_lo_r, id_lo_nxt;
  logic [TABLE_W-1:0]  id_hi_r, id_hi_nxt;
  logic [SLOT_W-1:0]   id_cnt_r, id_cnt_nxt;
  logic [SLOT_W-1:0]   opt_r, opt_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;
  logic                wsel_r, wsel_nxt;
  logic                lrs_r, lrs_nxt;
  logic                fresh_r, fresh_nxt;
  logic [SLOT_W-1:0]   j_r, j_nxt;
  logic                found_r, found_nxt;
  logic [ID_W-1:0]     fid_r, fid_nxt;
  logic [DATA_W-1:0]   fdata_r, fdata_nxt;
  logic [DEPTH-1:0]    vld_r, vld_nxt;
  logic                vldq_r, vldq_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]   out_idx_r, out_idx_nxt;
  logic [DATA_W-1:0]   out_data_r, out_data_nxt;
  logic                out_new_r, out_new_nxt;
  logic                out_last_r, out_last_nxt;

  logic [SLOT_W-1:0]   count;
  logic [SLOT_W:0]     opt_p1;
  logic [SLOT_W-1:0]   cmp_idx;
  logic                cmp_eq;
  logic [SLOT_W-1:0]   pos_upd;
  logic                ram_we, ram_re;
  logic [AW-1:0]       wr_addr, rd_addr;
  logic [DATA_W-1:0]   ram_rdata;

  assign count   = (id_cnt_r > CAP_C) ? CAP_C : id_cnt_r;
  assign opt_p1  = {1'b0, opt_r} + 5'd1;
  // the one comparator, shared by the skip check and the table search
  assign cmp_eq  = (table_id(id_lo_r, id_hi_r, cmp_idx) == fid_r);
  assign wr_addr = (wsel_r ? BANK_B : AW'(0)) + AW'(j_r);
  assign rd_addr = (wsel_r ? AW'(0) : BANK_B) + AW'(j_r);

  always_comb begin
    state_nxt     = state_r;
    id_lo_nxt     = id_lo_r;
    id_hi_nxt     = id_hi_r;
    id_cnt_nxt    = id_cnt_r;
    opt_nxt       = opt_r;
    pos_nxt       = pos_r;
    wsel_nxt      = wsel_r;
    lrs_nxt       = lrs_r;
    fresh_nxt     = fresh_r;
    j_nxt         = j_r;
    found_nxt     = found_r;
    fid_nxt       = fid_r;
    fdata_nxt     = fdata_r;
    vld_nxt       = vld_r;
    vldq_nxt      = vldq_r;
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_data_nxt  = out_data_r;
    out_new_nxt   = out_new_r;
    out_last_nxt  = out_last_r;
    cmp_idx       = j_r;
    pos_upd       = pos_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_ID_LOW:   id_lo_nxt  = cfg_wdata;
        CFG_ID_HIGH:  id_hi_nxt  = cfg_wdata;
        CFG_ID_COUNT: id_cnt_nxt = cfg_wdata[SLOT_W-1:0];
        CFG_OPT_SLOT: opt_nxt    = cfg_wdata[SLOT_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          fid_nxt   = in_ch.frame_id;
          fdata_nxt = in_ch.frame_data;
          j_nxt     = '0;
          if (in_ch.op == OP_FRAME) begin
            state_nxt = S_SKIP;
          end else begin
            fresh_nxt = (wsel_r != lrs_r);
            lrs_nxt   = wsel_r;
            if (count != '0) begin
              state_nxt = S_RADDR;
            end
          end
        end
      end
      S_SKIP: begin
        cmp_idx = opt_p1[SLOT_W-1:0];
        if ((pos_r == opt_r) && (opt_p1 < {1'b0, count}) && cmp_eq) begin
          pos_nxt = opt_p1[SLOT_W-1:0];
        end
        found_nxt = 1'b0;
        state_nxt = S_SEARCH;
      end
      S_SEARCH: begin
        if (j_r >= count) begin
          state_nxt = S_APPLY;
        end else if (cmp_eq) begin
          found_nxt = 1'b1;
          state_nxt = S_APPLY;
        end else begin
          j_nxt = j_r + 4'd1;
        end
      end
      S_APPLY: begin
        // j_r holds the lowest matching slot when found_r is set
        if (found_r) begin
          if (j_r == pos_r) begin
            ram_we           = 1'b1;
            vld_nxt[wr_addr] = 1'b1;
            pos_upd          = pos_r + 4'd1;
          end else begin
            pos_upd = '0;
          end
        end
        if (pos_upd == count) begin
          pos_nxt  = '0;
          wsel_nxt = ~wsel_r;
        end else begin
          pos_nxt = pos_upd;
        end
        state_nxt = S_IDLE;
      end
      S_RADDR: begin
        ram_re    = 1'b1;
        vldq_nxt  = vld_r[rd_addr];
        state_nxt = S_RLOAD;
      end
      S_RLOAD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = j_r;
          out_data_nxt  = vldq_r ? ram_rdata : '0;
          out_new_nxt   = fresh_r;
          out_last_nxt  = ((j_r + 4'd1) == count);
          if ((j_r + 4'd1) == count) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + 4'd1;
            state_nxt = S_RADDR;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      id_lo_r     <= '0;
      id_hi_r     <= '0;
      id_cnt_r    <= '0;
      opt_r       <= OPT_RESET;
      pos_r       <= '0;
      wsel_r      <= 1'b0;
      lrs_r       <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      id_lo_r     <= id_lo_nxt;
      id_hi_r     <= id_hi_nxt;
      id_cnt_r    <= id_cnt_nxt;
      opt_r       <= opt_nxt;
      pos_r       <= pos_nxt;
      wsel_r      <= wsel_nxt;
      lrs_r       <= lrs_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fresh_r    <= fresh_nxt;
    j_r        <= j_nxt;
    found_r    <= found_nxt;
    fid_r      <= fid_nxt;
    fdata_r    <= fdata_nxt;
    vldq_r     <= vldq_nxt;
    out_idx_r  <= out_idx_nxt;
    out_data_r <= out_data_nxt;
    out_new_r  <= out_new_nxt;
    out_last_r <= out_last_nxt;
  end

  cisa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (fdata_r),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.slot_index = out_idx_r;
  assign out_ch.slot_data  = out_data_r;
  assign out_ch.new_packet = out_new_r;
  assign out_ch.last       = out_last_r;

  `CISA_ASSERT_ALWAYS(a_pos_cap, pos_r <= TABLE_SLOTS_C, "sequence position past table")
  `CISA_ASSERT_IMP(a_load_src, $rose(out_valid_r), $past(state_r == S_RLOAD),
                   "output word loaded outside readout")
  `CISA_ASSERT_IMP(a_swap_src, $past(rst_n) && (wsel_r != $past(wsel_r)),
                   $past(state_r == S_APPLY), "buffer swap outside frame update")
  `CISA_ASSERT_IMP(a_last_idx, out_valid_r && out_last_r, (out_idx_r + 4'd1) == count,
                   "last flag not on final slot")

endmodule

// ----- sim/testbench.sv -----
// Testbench for can_id_sequence_assembler: frame and readout words in, slot words out.
// A scoreboard class predicts the slot buffers and checks every slot word in order.
// Depends on cisa_pkg, cisa_if and the assembler RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cisa_pkg::*;

  localparam int MAX_SLOTS   = 10;
  localparam int SETTLE      = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct {
    logic [SLOT_W-1:0] index;
    logic [DATA_W-1:0] data;
    logic              fresh;
    logic              last;
  } slot_word_t;

  class slot_scoreboard;
    logic [TABLE_W-1:0] id_low;
    logic [TABLE_W-1:0] id_high;
    logic [3:0]         id_count;
    logic [3:0]         opt_slot;
    logic [3:0]         position;
    logic               write_sel;
    logic               last_read_sel;
    logic [DATA_W-1:0]  slot_buf [2][MAX_SLOTS];
    slot_word_t         expected_q [$];
    int                 errors;

    function new();
      id_low        = '0;
      id_high       = '0;
      id_count      = '0;
      opt_slot      = OPT_RESET;
      position      = '0;
      write_sel     = 1'b0;
      last_read_sel = 1'b0;
      errors        = 0;
      foreach (slot_buf[b, s]) slot_buf[b][s] = '0;
    endfunction

    function void write_reg(cfg_addr_t addr, logic [TABLE_W-1:0] value);
      case (addr)
        CFG_ID_LOW:   id_low   = value;
        CFG_ID_HIGH:  id_high  = value;
        CFG_ID_COUNT: id_count = value[3:0];
        CFG_OPT_SLOT: opt_slot = value[3:0];
        default: ;
      endcase
    endfunction

    function int active_slots();
      int n;
      n = int'(id_count);
      if (n > MAX_SLOTS) n = MAX_SLOTS;
      if (n > TABLE_SLOTS) n = TABLE_SLOTS;
      return n;
    endfunction

    function logic [ID_W-1:0] slot_id(int s);
      if (s < 5) return id_low[11*s +: 11];
      if (s < TABLE_SLOTS) return id_high[11*(s-5) +: 11];
      return '0;
    endfunction

    function void note_word(op_t op, logic [ID_W-1:0] fid, logic [DATA_W-1:0] data);
      int         count;
      int         opt;
      int         pos;
      int         hit;
      int         j;
      bit         found;
      slot_word_t w;
      count = active_slots();
      if (op == OP_FRAME) begin
        opt   = int'(opt_slot);
        pos   = int'(position);
        found = 1'b0;
        hit   = 0;
        if (pos == opt && opt + 1 < count && fid == slot_id(opt + 1)) pos = opt + 1;
        // lowest matching slot wins
        for (j = 0; j < count; j++) begin
          if (!found && slot_id(j) == fid) begin
            hit   = j;
            found = 1'b1;
          end
        end
        if (found) begin
          if (hit == pos) begin
            slot_buf[write_sel][hit] = data;
            pos = (pos + 1) % 16;
          end else begin
            pos = 0;
          end
        end
        if (pos == count) begin
          pos       = 0;
          write_sel = !write_sel;
        end
        position = pos[3:0];
      end else begin
        w.fresh       = (write_sel != last_read_sel);
        last_read_sel = write_sel;
        for (j = 0; j < count; j++) begin
          w.index = SLOT_W'(j);
          w.data  = slot_buf[!write_sel][j];
          w.last  = (j + 1 == count);
          expected_q.push_back(w);
        end
      end
    endfunction

    function void mismatch(string field, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
    endfunction

    function void check_word(logic [SLOT_W-1:0] index, logic [DATA_W-1:0] data,
                             logic fresh, logic last);
      slot_word_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: slot word with nothing expected, expected none, got slot %0d data %h",
                 $time, index, data);
        return;
      end
      want = expected_q.pop_front();
      if (index !== want.index)
        mismatch("slot_index", DATA_W'(want.index), DATA_W'(index));
      if (data !== want.data)   mismatch("slot_data", want.data, data);
      if (fresh !== want.fresh)
        mismatch("new_packet", DATA_W'(want.fresh), DATA_W'(fresh));
      if (last !== want.last)
        mismatch("last", DATA_W'(want.last), DATA_W'(last));
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_addr_t          cfg_addr;
  logic [TABLE_W-1:0] cfg_wdata;

  cisa_in_if  in_ch ();
  cisa_out_if out_ch ();

  slot_scoreboard sb = new();

  int send_idle_pct;
  int recv_idle_pct;
  int sent_items;
  int cycle_count;
  int hold_left;
  bit hold_req;

  can_id_sequence_assembler #(.MAX_SLOTS(MAX_SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word(out_ch.slot_index, out_ch.slot_data, out_ch.new_packet, out_ch.last);
  end

  // receiver: random back-pressure plus an occasional long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_left    = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand_data();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [ID_W-1:0] rand_id();
    return ID_W'($urandom);
  endfunction

  // all sender tasks enter and leave on a falling edge
  task automatic send_word(op_t op, logic [ID_W-1:0] fid, logic [DATA_W-1:0] data);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.op         = op;
    in_ch.frame_id   = fid;
    in_ch.frame_data = data;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_word(op, fid, data);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic program_reg(cfg_addr_t addr, logic [TABLE_W-1:0] value);
    in_ch.valid = 1'b0;
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = value;
    sb.write_reg(addr, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_table(bit with_dup);
    logic [ID_W-1:0] ids [TABLE_SLOTS];
    bit              dup;
    int              k;
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      do begin
        ids[s] = rand_id();
        dup    = 1'b0;
        for (int t = 0; t < s; t++) if (ids[t] == ids[s]) dup = 1'b1;
      end while (dup);
    end
    if (with_dup) begin
      k      = $urandom_range(1, 3);
      ids[k] = ids[k-1];
    end
    program_reg(CFG_ID_LOW,  {ids[4], ids[3], ids[2], ids[1], ids[0]});
    program_reg(CFG_ID_HIGH, {ids[9], ids[8], ids[7], ids[6], ids[5]});
  endtask

  // in-order frames for one packet, maybe skipping the optional slot, with an occasional readout in between
  task automatic send_packet();
    int count;
    int opt;
    count = sb.active_slots();
    opt   = int'(sb.opt_slot);
    for (int s = 0; s < count; s++) begin
      if (s == opt && opt + 1 < count && $urandom_range(2) == 0) continue;
      if ($urandom_range(11) == 0) send_word(OP_READ, rand_id(), rand_data());
      send_word(OP_FRAME, sb.slot_id(s), rand_data());
    end
  endtask

  task automatic run_random(int n_items);
    int stop_at;
    int pick;
    int count;
    int cut;
    stop_at = sent_items + n_items;
    while (sent_items < stop_at) begin
      pick  = $urandom_range(99);
      count = sb.active_slots();
      if (pick < 55) begin
        send_packet();
      end else if (pick < 70) begin
        send_word(OP_READ, rand_id(), rand_data());
      end else if (pick < 80) begin
        send_word(OP_FRAME, rand_id(), rand_data());
      end else if (pick < 90 && count > 0) begin
        send_word(OP_FRAME, sb.slot_id($urandom_range(count - 1)), rand_data());
      end else if (pick < 97 && count > 0) begin
        // broken packet: a prefix, then some table ID
        cut = $urandom_range(count - 1);
        for (int s = 0; s < cut; s++) send_word(OP_FRAME, sb.slot_id(s), rand_data());
        send_word(OP_FRAME, sb.slot_id($urandom_range(count - 1)), rand_data());
      end else begin
        wait_drained();
      end
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_addr         = CFG_ID_LOW;
    cfg_wdata        = '0;
    in_ch.valid      = 1'b0;
    in_ch.op         = OP_FRAME;
    in_ch.frame_id   = '0;
    in_ch.frame_data = '0;
    hold_req         = 1'b0;
    sent_items       = 0;
    cycle_count      = 0;
    send_idle_pct    = 18;
    recv_idle_pct    = 87;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero count: every frame swaps, a readout yields no words
    program_reg(CFG_ID_COUNT, '0);
    send_word(OP_FRAME, '0, '0);
    send_word(OP_FRAME, '1, '1);
    send_word(OP_READ, '0, '0);
    wait_drained();

    program_reg(CFG_ID_LOW,  {11'h001, 11'h2AA, 11'h155, 11'h000, 11'h7FF});
    program_reg(CFG_ID_HIGH, {11'h789, 11'h456, 11'h123, 11'h3FF, 11'h400});
    program_reg(CFG_ID_COUNT, 5);
    send_word(OP_FRAME, 11'h7FF, '1);
    send_word(OP_FRAME, 11'h000, '0);
    send_word(OP_FRAME, 11'h155, {4{16'h5555}});
    send_word(OP_FRAME, 11'h2AA, {4{16'hAAAA}});
    send_word(OP_FRAME, 11'h001, rand_data());
    send_word(OP_READ, '1, '1);
    send_word(OP_READ, '0, '0);
    // slot 3 skipped by the slot-4 ID
    send_word(OP_FRAME, 11'h7FF, rand_data());
    send_word(OP_FRAME, 11'h000, rand_data());
    send_word(OP_FRAME, 11'h155, rand_data());
    send_word(OP_FRAME, 11'h001, rand_data());
    // out of order table ID drops the frame and restarts
    send_word(OP_FRAME, 11'h7FF, rand_data());
    send_word(OP_FRAME, 11'h155, rand_data());
    send_word(OP_FRAME, 11'h7FE, rand_data());
    send_word(OP_READ, rand_id(), rand_data());
    wait_drained();
    // count above the table size reads all ten slots
    program_reg(CFG_ID_COUNT, 15);
    send_word(OP_READ, rand_id(), rand_data());
    wait_drained();
    program_reg(CFG_ID_COUNT, 5);
    send_word(OP_FRAME, 11'h7FF, rand_data());
    send_word(OP_FRAME, 11'h000, rand_data());
    send_word(OP_FRAME, 11'h155, rand_data());
    wait_drained();
    // count lowered onto the position: next frame of any ID completes
    program_reg(CFG_ID_COUNT, 3);
    send_word(OP_FRAME, 11'h7FE, rand_data());
    send_word(OP_READ, rand_id(), rand_data());

    for (int phase = 0; phase < 6; phase++) begin
      wait_drained();
      if (phase == 2) begin
        send_idle_pct = 87;
        recv_idle_pct = 18;
      end
      if (phase == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (phase)
        0: begin
          load_table(1'b0);
          program_reg(CFG_ID_COUNT, 10);
          program_reg(CFG_OPT_SLOT, 8);
        end
        1: begin
          program_reg(CFG_ID_LOW, '1);
          program_reg(CFG_ID_HIGH, '0);
          program_reg(CFG_ID_COUNT, 1);
          program_reg(CFG_OPT_SLOT, 0);
        end
        2: begin
          load_table(1'b0);
          program_reg(CFG_ID_COUNT, 15);
          program_reg(CFG_OPT_SLOT, 0);
        end
        3: begin
          load_table(1'b1);
          program_reg(CFG_ID_COUNT, 4);
          program_reg(CFG_OPT_SLOT, 2);
        end
        4: begin
          load_table(1'b0);
          program_reg(CFG_ID_COUNT, 10);
          program_reg(CFG_OPT_SLOT, 3);
          send_packet();
          // receiver stalls while readouts keep coming: input must back up
          hold_req = 1'b1;
          repeat (6) send_word(OP_READ, rand_id(), rand_data());
        end
        default: begin
          load_table(1'b0);
          program_reg(CFG_ID_COUNT, TABLE_W'($urandom_range(15)));
          program_reg(CFG_OPT_SLOT, TABLE_W'($urandom_range(8)));
        end
      endcase
      run_random(65);
    end

    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
